// ----- hdl/lru_read_cache_tags_defines.svh -----
// Assertion macros for the LRU read cache tag directory.
// Expects clk and rst in the scope where a macro is used.
`ifndef LRU_READ_CACHE_TAGS_DEFINES_SVH
`define LRU_READ_CACHE_TAGS_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define LRC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define LRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/lrc_pkg.sv -----
// Shared types and constants for the LRU read cache tag directory.
// No dependencies.
`default_nettype none
package lrc_pkg;
  localparam int SLOTS_DEF      = 64;
  localparam int SLOT_BYTES_DEF = 4096;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_W          = 7;
  localparam int OP_W           = 2;
  localparam int LBA_W          = 64;
  localparam int LEN_W          = 32;
  localparam int CNT_W          = 32;
  localparam int STAT_W         = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_INVAL  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_MISS     = 2'd1,
    ST_OVERSIZE = 2'd2
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [LBA_W-1:0] lba;
    logic [LEN_W-1:0] length;
    logic             oversize;
  } req_t;
endpackage
`default_nettype wire

// ----- hdl/lrc_front.sv -----
// Front end: accepts requests and classifies them (oversized inserts).
// Depends on lrc_pkg.
`default_nettype none
module lrc_front #(
  parameter int SLOT_BYTES = lrc_pkg::SLOT_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [lrc_pkg::OP_W-1:0]  op,
  input  logic [lrc_pkg::LBA_W-1:0] lba,
  input  logic [lrc_pkg::LEN_W-1:0] length,
  output logic                      req_valid,
  input  logic                      req_ready,
  output lrc_pkg::req_t             req
);
  import lrc_pkg::*;

  assign in_ready = !req_valid || req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      req.op       <= op_t'(op);
      req.lba      <= lba;
      req.length   <= length;
      req.oversize <= (op_t'(op) == OP_INSERT) && (length > LEN_W'(SLOT_BYTES));
    end
  end
endmodule
`default_nettype wire

// ----- hdl/lrc_queue.sv -----
// Short request queue between front end and back end.
// Depends on lrc_pkg.
`default_nettype none
module lrc_queue #(
  parameter int DEPTH = lrc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  lrc_pkg::req_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output lrc_pkg::req_t rd_data
);
  import lrc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  req_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/lrc_back.sv -----
// Back end: tag directory, LRU ranks, counters and the result register.
// Depends on lrc_pkg and lru_read_cache_tags_defines.svh.
`default_nettype none
`include "lru_read_cache_tags_defines.svh"
module lrc_back #(
  parameter int SLOTS      = lrc_pkg::SLOTS_DEF,
  parameter int SLOT_BYTES = lrc_pkg::SLOT_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lrc_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  lrc_pkg::req_t                       q_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lrc_pkg::STAT_W-1:0]          status,
  output logic [$clog2(SLOTS)-1:0]            slot,
  output logic [$clog2(SLOT_BYTES+1)-1:0]     stored_length,
  output logic [lrc_pkg::CNT_W-1:0]           total_hits,
  output logic [lrc_pkg::CNT_W-1:0]           total_misses,
  output logic [$clog2(SLOTS+1)-1:0]          used_slots
);
  import lrc_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int AW = $clog2(SLOTS + 1);
  localparam int LW = $clog2(SLOT_BYTES + 1);
  localparam int GS = 8;
  localparam int NG = (SLOTS + GS - 1) / GS;

  typedef enum logic [2:0] {S_IDLE, S_CMP, S_GRP, S_SEL, S_UPD} state_t;

  state_t           state;
  req_t             cur;
  logic [LBA_W-1:0] tag_addr [SLOTS];
  logic [LW-1:0]    tag_len  [SLOTS];
  logic [SLOTS-1:0] tag_vld;
  logic [SW-1:0]    rank     [SLOTS];
  logic [AW-1:0]    active;
  logic [CNT_W-1:0] hits;
  logic [CNT_W-1:0] misses;
  logic [AW-1:0]    used_total;

  logic [SLOTS-1:0] act_mask;
  logic [SLOTS-1:0] hit_vec_next, hit_vec;
  logic [SLOTS-1:0] inv_vec_next, inv_vec;
  logic [SW-1:0]    victim_next, victim;
  logic [NG-1:0]    gfound_next, gfound;
  logic [SW-1:0]    gidx_next [NG];
  logic [SW-1:0]    gidx      [NG];
  logic [SW-1:0]    grank_next [NG];
  logic [SW-1:0]    grank      [NG];
  logic             found_next, found;
  logic [SW-1:0]    best_next, best;
  logic [AW-1:0]    cfg_active;
  logic             upd_go;
  logic             prom_en;
  logic [SW-1:0]    prom_slot;
  logic [SW-1:0]    prom_rank;

  logic [STAT_W-1:0] status_next;
  logic [SW-1:0]     slot_next;
  logic [LW-1:0]     stored_length_next;
  logic [CNT_W-1:0]  hits_next;
  logic [CNT_W-1:0]  misses_next;
  logic [AW-1:0]     used_total_next;
  logic [SLOTS-1:0]  tag_vld_next;
  logic [SW-1:0]     rank_next [SLOTS];
  logic              out_valid_next;

  assign cfg_ready = 1'b1;
  assign q_ready   = (state == S_IDLE) && !cfg_valid;
  assign upd_go    = (state == S_UPD) && (!out_valid || out_ready);

  always_comb begin
    if (cfg_data == '0) begin
      cfg_active = AW'(1);
    end else if (int'(cfg_data) > SLOTS) begin
      cfg_active = AW'(SLOTS);
    end else begin
      cfg_active = AW'(cfg_data);
    end
  end

  // Parallel tag compare and victim search, one lane per slot.
  always_comb begin
    victim_next = '0;
    for (int i = 0; i < SLOTS; i++) begin
      act_mask[i] = (AW'(i) < active);
      hit_vec_next[i] = act_mask[i] && tag_vld[i] && (tag_addr[i] == cur.lba) &&
                        (LEN_W'(tag_len[i]) >= cur.length);
      inv_vec_next[i] = act_mask[i] && tag_vld[i] && (tag_addr[i] >= cur.lba) &&
                        ((tag_addr[i] - cur.lba) < LBA_W'(cur.length));
      if (act_mask[i] && (rank[i] == SW'(active - 1'b1))) begin
        victim_next = victim_next | SW'(i);
      end
    end
  end

  // Most recent hit: per-group minimum rank, then across groups.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      gfound_next[g] = 1'b0;
      gidx_next[g]   = '0;
      grank_next[g]  = '0;
      for (int k = 0; k < GS; k++) begin
        if (g * GS + k < SLOTS) begin
          if (hit_vec[SW'(g * GS + k)] &&
              (!gfound_next[g] || rank[SW'(g * GS + k)] < grank_next[g])) begin
            gfound_next[g] = 1'b1;
            gidx_next[g]   = SW'(g * GS + k);
            grank_next[g]  = rank[SW'(g * GS + k)];
          end
        end
      end
    end
  end

  always_comb begin
    logic [SW-1:0] br;
    br         = '0;
    found_next = 1'b0;
    best_next  = '0;
    for (int g = 0; g < NG; g++) begin
      if (gfound[g] && (!found_next || grank[g] < br)) begin
        found_next = 1'b1;
        best_next  = gidx[g];
        br         = grank[g];
      end
    end
  end

  always_comb begin
    prom_en   = 1'b0;
    prom_slot = '0;
    if (cur.op == OP_INSERT && !cur.oversize) begin
      prom_en   = 1'b1;
      prom_slot = victim;
    end else if (cur.op == OP_LOOKUP && found) begin
      prom_en   = 1'b1;
      prom_slot = best;
    end
    prom_rank = rank[prom_slot];
  end

  // Result and state updates for the request in S_UPD.
  always_comb begin
    status_next        = ST_OK;
    slot_next          = '0;
    stored_length_next = '0;
    hits_next          = hits;
    misses_next        = misses;
    used_total_next    = used_total;
    tag_vld_next       = tag_vld;
    for (int i = 0; i < SLOTS; i++) begin
      if (prom_en && act_mask[i] && rank[i] < prom_rank) begin
        rank_next[i] = rank[i] + 1'b1;
      end else begin
        rank_next[i] = rank[i];
      end
    end
    if (prom_en) begin
      rank_next[prom_slot] = '0;
    end
    case (cur.op)
      OP_INSERT: begin
        if (cur.oversize) begin
          status_next = ST_OVERSIZE;
        end else begin
          tag_vld_next[victim] = 1'b1;
          slot_next            = victim;
          if (used_total < active) begin
            used_total_next = used_total + 1'b1;
          end
        end
      end
      OP_LOOKUP: begin
        if (found) begin
          hits_next          = hits + 1'b1;
          slot_next          = best;
          stored_length_next = tag_len[best];
        end else begin
          misses_next = misses + 1'b1;
          status_next = ST_MISS;
        end
      end
      OP_INVAL: begin
        tag_vld_next = tag_vld & ~inv_vec;
      end
      default: begin
        tag_vld_next    = '0;
        hits_next       = '0;
        misses_next     = '0;
        used_total_next = '0;
      end
    endcase
    if (upd_go) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      active     <= AW'(SLOTS);
      tag_vld    <= '0;
      hits       <= '0;
      misses     <= '0;
      used_total <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        rank[i] <= SW'(i);
      end
    end else if (cfg_valid) begin
      active     <= cfg_active;
      tag_vld    <= '0;
      hits       <= '0;
      misses     <= '0;
      used_total <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        rank[i] <= SW'(i);
      end
    end else begin
      out_valid <= out_valid_next;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_data;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          hit_vec <= hit_vec_next;
          inv_vec <= inv_vec_next;
          victim  <= victim_next;
          state   <= S_GRP;
        end
        S_GRP: begin
          gfound <= gfound_next;
          for (int g = 0; g < NG; g++) begin
            gidx[g]  <= gidx_next[g];
            grank[g] <= grank_next[g];
          end
          state <= S_SEL;
        end
        S_SEL: begin
          found <= found_next;
          best  <= best_next;
          state <= S_UPD;
        end
        S_UPD: begin
          if (upd_go) begin
            status        <= status_next;
            slot          <= slot_next;
            stored_length <= stored_length_next;
            total_hits    <= hits_next;
            total_misses  <= misses_next;
            used_slots    <= used_total_next;
            hits          <= hits_next;
            misses        <= misses_next;
            used_total    <= used_total_next;
            tag_vld       <= tag_vld_next;
            for (int i = 0; i < SLOTS; i++) begin
              rank[i] <= rank_next[i];
            end
            if (cur.op == OP_INSERT && !cur.oversize) begin
              tag_addr[victim] <= cur.lba;
              tag_len[victim]  <= LW'(cur.length);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LRC_ASSERT_ALWAYS(a_used_bound, used_total <= active, "used count above active slots")
  `LRC_ASSERT_ALWAYS(a_vld_in_range, (tag_vld & ~act_mask) == '0, "valid slot beyond active")
  `LRC_ASSERT_NEXT(a_promote_mru, upd_go && prom_en && !cfg_valid, rank[prom_slot] == '0, "no MRU")
  `LRC_ASSERT_NEXT(a_result_out, upd_go && !cfg_valid, out_valid, "update posted no result")
endmodule
`default_nettype wire

// ----- hdl/lru_read_cache_tags.sv -----
// LRU read cache tags: a request passes the front register, queue write, back end
// capture, compare, group and final select, and update before the result is valid.
// One request in the back end at a time: it takes the next only back in S_IDLE.
// Front register and 2-entry queue accept while the back end works, until they fill.
// Synchronous reset: 64 (SLOTS) active slots, all invalid, slot 0 most recent,
// counters zero; a config write does likewise, but active slots come from cfg_data.
`default_nettype none
module lru_read_cache_tags #(
  parameter int SLOTS      = lrc_pkg::SLOTS_DEF,
  parameter int SLOT_BYTES = lrc_pkg::SLOT_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lrc_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lrc_pkg::OP_W-1:0]        op,
  input  logic [lrc_pkg::LBA_W-1:0]       lba,
  input  logic [lrc_pkg::LEN_W-1:0]       length,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lrc_pkg::STAT_W-1:0]      status,
  output logic [$clog2(SLOTS)-1:0]        slot,
  output logic [$clog2(SLOT_BYTES+1)-1:0] stored_length,
  output logic [lrc_pkg::CNT_W-1:0]       total_hits,
  output logic [lrc_pkg::CNT_W-1:0]       total_misses,
  output logic [$clog2(SLOTS+1)-1:0]      used_slots
);
  import lrc_pkg::*;

  logic req_valid;
  logic req_ready;
  req_t req;
  logic q_valid;
  logic q_ready;
  req_t q_data;

  lrc_front #(.SLOT_BYTES(SLOT_BYTES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .lba       (lba),
    .length    (length),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req)
  );

  lrc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (req_valid),
    .wr_ready (req_ready),
    .wr_data  (req),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  lrc_back #(.SLOTS(SLOTS), .SLOT_BYTES(SLOT_BYTES)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_data        (q_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .slot          (slot),
    .stored_length (stored_length),
    .total_hits    (total_hits),
    .total_misses  (total_misses),
    .used_slots    (used_slots)
  );
endmodule
`default_nettype wire
